FILE: rtl/mbwm_pkg.sv
package mbwm_pkg;

   // grid defaults
   localparam int GRID_COLS_DEF    = 24;
   localparam int GRID_ROWS_DEF    = 12;
   localparam int BLOCK_WIDTH_DEF  = 32;
   localparam int BLOCK_HEIGHT_DEF = 32;

   // field widths
   localparam int IDX_W  = 9;
   localparam int PIX_W  = 8;
   localparam int TIME_W = 32;
   localparam int W_W    = 17;
   localparam int SUM_W  = 18;
   localparam int NUT_W  = 33;
   localparam int DIV_W  = 18;
   localparam int Q_W    = 17;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [W_W-1:0]    ONE_Q16      = 17'h10000;
   localparam logic [SUM_W-1:0]  SUM_MAX      = '1;
   localparam logic [NUT_W-1:0]  TIME_MAX     = '1;
   localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_a;
      logic [PIX_W-1:0]  pixel_b;
      logic              last_in_frame;
      logic [TIME_W-1:0] frame_time;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] block_index;
      logic [W_W-1:0]   block_weight;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  blk_idx;
      logic [PIX_W-1:0]  diff;
      logic              last;
      logic [TIME_W-1:0] frame_time;
   } work_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/mbwm_front.sv
module mbwm_front #(
   parameter int GRID_COLS    = mbwm_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS    = mbwm_pkg::GRID_ROWS_DEF,
   parameter int BLOCK_WIDTH  = mbwm_pkg::BLOCK_WIDTH_DEF,
   parameter int BLOCK_HEIGHT = mbwm_pkg::BLOCK_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  mbwm_pkg::req_type  req_data,
   input  logic               clearing,
   input  logic               q_full,
   output logic               q_push,
   output mbwm_pkg::work_type q_item
);
   import mbwm_pkg::*;

   localparam int CW  = (BLOCK_WIDTH > 1)  ? $clog2(BLOCK_WIDTH)  : 1;
   localparam int BCW = (GRID_COLS > 1)    ? $clog2(GRID_COLS)    : 1;
   localparam int RW  = (BLOCK_HEIGHT > 1) ? $clog2(BLOCK_HEIGHT) : 1;
   localparam int BRW = (GRID_ROWS > 1)    ? $clog2(GRID_ROWS)    : 1;

   logic [CW-1:0]  col_ff, col_in;
   logic [BCW-1:0] bcol_ff, bcol_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [BRW-1:0] brow_ff, brow_in;
   logic           accept;

   assign full   = q_full | clearing;
   assign accept = push & ~full;
   assign q_push = accept;

   always_comb begin
      q_item.blk_idx    = IDX_W'(int'(brow_ff) * GRID_COLS + int'(bcol_ff));
      q_item.diff       = (req_data.pixel_a > req_data.pixel_b) ?
                          req_data.pixel_a - req_data.pixel_b :
                          req_data.pixel_b - req_data.pixel_a;
      q_item.last       = req_data.last_in_frame;
      q_item.frame_time = req_data.frame_time;
   end

   // raster position split into block and offset within block
   always_comb begin
      col_in  = col_ff;
      bcol_in = bcol_ff;
      row_in  = row_ff;
      brow_in = brow_ff;
      if (accept) begin
         if (req_data.last_in_frame) begin
            col_in  = '0;
            bcol_in = '0;
            row_in  = '0;
            brow_in = '0;
         end else if (col_ff == CW'(BLOCK_WIDTH - 1)) begin
            col_in = '0;
            if (bcol_ff == BCW'(GRID_COLS - 1)) begin
               bcol_in = '0;
               if (row_ff == RW'(BLOCK_HEIGHT - 1)) begin
                  row_in = '0;
                  if (brow_ff == BRW'(GRID_ROWS - 1)) begin
                     brow_in = '0;
                  end else begin
                     brow_in = brow_ff + 1'b1;
                  end
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               bcol_in = bcol_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         bcol_ff <= '0;
         row_ff  <= '0;
         brow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         bcol_ff <= bcol_in;
         row_ff  <= row_in;
         brow_ff <= brow_in;
      end
   end

endmodule

FILE: rtl/mbwm_queue.sv
module mbwm_queue #(
   parameter int DEPTH = mbwm_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbwm_pkg::work_type item_in,
   input  logic               pop,
   output mbwm_pkg::work_type item_out,
   output logic               full,
   output logic               empty
);
   import mbwm_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_type         mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == (PW + 1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign item_out = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/mbwm_div.sv
module mbwm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mbwm_pkg::div_req_type req,
   output mbwm_pkg::div_rsp_type rsp
);
   import mbwm_pkg::*;

   // dividend <= divisor, so the quotient of dividend*2^16/divisor fits Q_W bits
   localparam int CNT_W = $clog2(Q_W);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W:0]   rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [Q_W-1:0]   quo_ff;
   logic             ge;
   logic [DIV_W:0]   rem_sub;

   assign ge      = rem_ff >= {1'b0, dvs_ff};
   assign rem_sub = ge ? rem_ff - {1'b0, dvs_ff} : rem_ff;

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff  <= {1'b0, req.dividend};
            dvs_ff  <= req.divisor;
            quo_ff  <= '0;
            cnt_ff  <= CNT_W'(Q_W - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[Q_W-2:0], ge};
            rem_ff <= {rem_sub[DIV_W-1:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

endmodule

FILE: rtl/mbwm_back.sv
module mbwm_back #(
   parameter int NBLK = mbwm_pkg::GRID_COLS_DEF * mbwm_pkg::GRID_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [mbwm_pkg::TIME_W-1:0] csr_write_data,
   input  logic                        q_empty,
   input  mbwm_pkg::work_type          q_item,
   output logic                        q_pop,
   input  logic                        pop,
   output logic                        empty,
   output mbwm_pkg::rsp_type           rsp_data,
   output logic                        clearing,
   output mbwm_pkg::div_req_type       div_req,
   input  mbwm_pkg::div_rsp_type       div_rsp
);
   import mbwm_pkg::*;

   localparam int AW = (NBLK > 1) ? $clog2(NBLK) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PIX, S_ZERO, S_PK_RD, S_PK_WR,
      S_UP_RD, S_UP_DIV, S_UP_WAIT, S_NM_RD, S_NM_DIV, S_NM_WAIT
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     ptr_ff;
   work_type          cur_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  gp_ff;
   logic [W_W-1:0]    wmax_ff;
   logic [NUT_W-1:0]  nut_ff;
   logic [TIME_W-1:0] period_ff;
   logic [W_W-1:0]    lat_w_ff;

   logic [SUM_W-1:0] sum_mem [NBLK];
   logic [SUM_W-1:0] peak_mem [NBLK];
   logic [W_W-1:0]   w_mem [NBLK];
   logic [SUM_W-1:0] sum_rd_ff, peak_rd_ff;
   logic [W_W-1:0]   w_rd_ff;

   logic [AW-1:0]    ra, wa;
   logic             sum_we, peak_we, w_we;
   logic [SUM_W-1:0] sum_wd, peak_wd;
   logic [W_W-1:0]   w_wd;
   logic [SUM_W:0]   sum_add;
   logic [W_W-1:0]   up_w, wmax_cand;
   logic [NUT_W:0]   nut_add;
   logic             ptr_last;

   function automatic logic [W_W-1:0] blend(logic [W_W-1:0] w, logic [W_W-1:0] r);
      logic [W_W+1:0] s;
      s = {2'b00, w} + {1'b0, w, 1'b0} + {2'b00, r};
      s = s >> 2;
      if (s > {2'b00, ONE_Q16}) begin
         s = {2'b00, ONE_Q16};
      end
      return s[W_W-1:0];
   endfunction

   assign ptr_last  = (ptr_ff == AW'(NBLK - 1));
   assign clearing  = (state_ff == S_CLEAR);
   assign empty     = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty && !rsp_valid_ff;
   assign sum_add   = {1'b0, sum_rd_ff} + (SUM_W + 1)'(cur_ff.diff);
   assign up_w      = (state_ff == S_UP_DIV) ? blend(w_rd_ff, '0) :
                      blend(lat_w_ff, div_rsp.quotient);
   assign wmax_cand = (up_w > wmax_ff) ? up_w : wmax_ff;
   assign nut_add   = {1'b0, nut_ff} + (NUT_W + 1)'(period_ff);

   always_comb begin
      ra = (state_ff == S_IDLE) ? AW'(q_item.blk_idx) : ptr_ff;
      div_req.start    = ((state_ff == S_UP_DIV) && (gp_ff != '0)) ||
                         (state_ff == S_NM_DIV);
      div_req.dividend = (state_ff == S_NM_DIV) ? {1'b0, w_rd_ff} : peak_rd_ff;
      div_req.divisor  = (state_ff == S_NM_DIV) ? {1'b0, wmax_ff} : gp_ff;
   end

   // memory write port control
   always_comb begin
      wa      = ptr_ff;
      sum_we  = 1'b0;
      peak_we = 1'b0;
      w_we    = 1'b0;
      sum_wd  = '0;
      peak_wd = '0;
      w_wd    = ONE_Q16;
      case (state_ff)
         S_CLEAR, S_ZERO: begin
            sum_we  = 1'b1;
            peak_we = 1'b1;
            w_we    = 1'b1;
         end
         S_PIX: begin
            wa     = AW'(cur_ff.blk_idx);
            sum_we = 1'b1;
            sum_wd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
         end
         S_PK_WR: begin
            sum_we  = 1'b1;
            peak_we = 1'b1;
            peak_wd = (sum_rd_ff > peak_rd_ff) ? sum_rd_ff : peak_rd_ff;
         end
         S_UP_DIV: begin
            w_we    = (gp_ff == '0);
            peak_we = (gp_ff == '0);
            w_wd    = up_w;
         end
         S_UP_WAIT: begin
            w_we    = div_rsp.done;
            peak_we = div_rsp.done;
            w_wd    = up_w;
         end
         S_NM_WAIT: begin
            w_we = div_rsp.done;
            w_wd = div_rsp.quotient;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[wa] <= sum_wd;
      end
      if (peak_we) begin
         peak_mem[wa] <= peak_wd;
      end
      if (w_we) begin
         w_mem[wa] <= w_wd;
      end
      sum_rd_ff  <= sum_mem[ra];
      peak_rd_ff <= peak_mem[ra];
      w_rd_ff    <= w_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gp_ff        <= '0;
         wmax_ff      <= '0;
         nut_ff       <= {1'b0, PERIOD_RESET};
         period_ff    <= PERIOD_RESET;
      end else begin
         if (csr_write_en) begin
            period_ff <= csr_write_data;
         end
         if (pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR, S_ZERO: begin
               gp_ff <= '0;
               if (ptr_last) begin
                  ptr_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  cur_ff   <= q_item;
                  state_ff <= S_PIX;
               end
            end
            S_PIX: begin
               rsp_ff.block_index  <= cur_ff.blk_idx;
               rsp_ff.block_weight <= w_rd_ff;
               rsp_valid_ff        <= 1'b1;
               ptr_ff              <= '0;
               if (!cur_ff.last) begin
                  state_ff <= S_IDLE;
               end else if (cur_ff.frame_time == '0) begin
                  state_ff <= S_ZERO;
               end else begin
                  state_ff <= S_PK_RD;
               end
            end
            S_PK_RD: begin
               state_ff <= S_PK_WR;
            end
            S_PK_WR: begin
               if ((sum_rd_ff > peak_rd_ff) && (sum_rd_ff >= gp_ff)) begin
                  gp_ff <= sum_rd_ff;
               end
               if (ptr_last) begin
                  ptr_ff  <= '0;
                  wmax_ff <= '0;
                  if ({1'b0, cur_ff.frame_time} >= nut_ff) begin
                     state_ff <= S_UP_RD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  ptr_ff   <= ptr_ff + 1'b1;
                  state_ff <= S_PK_RD;
               end
            end
            S_UP_RD: begin
               state_ff <= S_UP_DIV;
            end
            S_UP_DIV, S_UP_WAIT: begin
               if (state_ff == S_UP_DIV && gp_ff != '0) begin
                  lat_w_ff <= w_rd_ff;
                  state_ff <= S_UP_WAIT;
               end else if (state_ff == S_UP_DIV || div_rsp.done) begin
                  wmax_ff <= wmax_cand;
                  if (!ptr_last) begin
                     ptr_ff   <= ptr_ff + 1'b1;
                     state_ff <= S_UP_RD;
                  end else if (wmax_cand != '0) begin
                     ptr_ff   <= '0;
                     state_ff <= S_NM_RD;
                  end else begin
                     gp_ff    <= '0;
                     nut_ff   <= nut_add[NUT_W] ? TIME_MAX : nut_add[NUT_W-1:0];
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_NM_RD: begin
               state_ff <= S_NM_DIV;
            end
            S_NM_DIV: begin
               state_ff <= S_NM_WAIT;
            end
            S_NM_WAIT: begin
               if (div_rsp.done) begin
                  if (ptr_last) begin
                     ptr_ff   <= '0;
                     gp_ff    <= '0;
                     nut_ff   <= nut_add[NUT_W] ? TIME_MAX : nut_add[NUT_W-1:0];
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff   <= ptr_ff + 1'b1;
                     state_ff <= S_NM_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/motion_block_weight_map.sv
// channel | ports                          | transaction when
// --------+--------------------------------+------------------------------
// pixels  | push, full, req_data           | push high, full low
// results | pop, empty, rsp_data           | pop high, empty low
// csr     | csr_write_en, csr_write_data   | csr_write_en high
//
// in the back end a pixel is read from the block memories, then updated and issued,
// the front takes one per cycle into a 4-deep queue while the queue is not full and no clear runs
// frame end with nonzero time: a peak pass (read, write) over every block, and on an
// update a pass per block for blend and again for normalize (17-step divider)
// after reset a clearing pass of one block a cycle (288 at defaults) holds full high
// results wait in a one-entry output register; the back end takes no new pixel until it is taken
module motion_block_weight_map #(
   parameter int GRID_COLS    = mbwm_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS    = mbwm_pkg::GRID_ROWS_DEF,
   parameter int BLOCK_WIDTH  = mbwm_pkg::BLOCK_WIDTH_DEF,
   parameter int BLOCK_HEIGHT = mbwm_pkg::BLOCK_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  mbwm_pkg::req_type           req_data,
   output logic                        empty,
   input  logic                        pop,
   output mbwm_pkg::rsp_type           rsp_data,
   input  logic                        csr_write_en,
   input  logic [mbwm_pkg::TIME_W-1:0] csr_write_data
);
   import mbwm_pkg::*;

   work_type    q_in, q_out;
   logic        q_push, q_pop, q_full, q_empty, clearing;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // front: raster tracking, block index and absolute difference
   mbwm_front #(
      .GRID_COLS   (GRID_COLS),
      .GRID_ROWS   (GRID_ROWS),
      .BLOCK_WIDTH (BLOCK_WIDTH),
      .BLOCK_HEIGHT(BLOCK_HEIGHT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .clearing(clearing),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_item  (q_in)
   );

   // decouples front and back
   mbwm_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .item_in (q_in),
      .pop     (q_pop),
      .item_out(q_out),
      .full    (q_full),
      .empty   (q_empty)
   );

   // shared divider for peak ratio and weight normalization
   mbwm_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   // back: block memories, result register, frame-end sequencer
   mbwm_back #(
      .NBLK(GRID_COLS * GRID_ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .q_empty       (q_empty),
      .q_item        (q_out),
      .q_pop         (q_pop),
      .pop           (pop),
      .empty         (empty),
      .rsp_data      (rsp_data),
      .clearing      (clearing),
      .div_req       (div_req),
      .div_rsp       (div_rsp)
   );

endmodule

FILE: tb/mbwm_checker.sv
`timescale 1ns / 1ps

module mbwm_checker
   import mbwm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                full,
   input  req_type             req_data,
   input  logic                pop,
   input  logic                empty,
   input  rsp_type             rsp_data,
   input  logic                csr_write_en,
   input  logic [TIME_W-1:0]   csr_write_data,
   output int                  errors,
   output int                  outstanding
);

   localparam int NUM_BLOCKS = GRID_COLS_DEF * GRID_ROWS_DEF;
   localparam int RASTER_W   = GRID_COLS_DEF * BLOCK_WIDTH_DEF;
   localparam int RASTER_H   = GRID_ROWS_DEF * BLOCK_HEIGHT_DEF;

   logic [TIME_W-1:0] period;
   logic [SUM_W-1:0]  motion_sum  [NUM_BLOCKS];
   logic [SUM_W-1:0]  motion_peak [NUM_BLOCKS];
   logic [W_W-1:0]    weight      [NUM_BLOCKS];
   logic [SUM_W-1:0]  top_peak;
   logic [NUT_W-1:0]  update_due;
   int unsigned       column;
   int unsigned       row;
   rsp_type           weight_q[$];

   task automatic restart_map();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         motion_sum[i]  = '0;
         motion_peak[i] = '0;
         weight[i]      = ONE_Q16;
      end
      top_peak   = '0;
      update_due = NUT_W'(PERIOD_RESET);
      period     = PERIOD_RESET;
      column     = 0;
      row        = 0;
   endtask

   // frame end: zero time restarts weights and peaks; else peaks, then blend and renormalize at the update time
   task automatic close_frame(input logic [TIME_W-1:0] t);
      longint unsigned ratio, w, wmax, due;
      wmax = 0;
      if (t == 0) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            weight[i]      = ONE_Q16;
            motion_peak[i] = '0;
         end
         top_peak = '0;
      end else begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (motion_sum[i] > motion_peak[i]) begin
               motion_peak[i] = motion_sum[i];
               if (motion_peak[i] >= top_peak) top_peak = motion_peak[i];
            end
         end
         if (longint'(t) >= longint'(update_due)) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
               ratio = 0;
               if (top_peak != 0)
                  ratio = (longint'(motion_peak[i]) * 65536) / longint'(top_peak);
               w = (3 * longint'(weight[i]) + ratio) / 4;
               if (w > 65536) w = 65536;
               weight[i] = W_W'(w);
               if (w > wmax) wmax = w;
               motion_peak[i] = '0;
            end
            if (wmax != 0)
               for (int i = 0; i < NUM_BLOCKS; i++)
                  weight[i] = W_W'((longint'(weight[i]) * 65536) / wmax);
            top_peak = '0;
            due = longint'(update_due) + longint'(period);
            update_due = (due > longint'(TIME_MAX)) ? TIME_MAX : NUT_W'(due);
         end
      end
      for (int i = 0; i < NUM_BLOCKS; i++) motion_sum[i] = '0;
      column = 0;
      row    = 0;
   endtask

   task automatic take_pixel(input req_type r);
      int unsigned idx, sum;
      rsp_type     e;
      idx = (row / BLOCK_HEIGHT_DEF) * GRID_COLS_DEF + column / BLOCK_WIDTH_DEF;
      if (idx >= NUM_BLOCKS) idx = NUM_BLOCKS - 1;
      e.block_index  = IDX_W'(idx);
      e.block_weight = weight[idx];
      weight_q.push_back(e);
      sum = motion_sum[idx] + ((r.pixel_a > r.pixel_b) ? r.pixel_a - r.pixel_b
                                                      : r.pixel_b - r.pixel_a);
      motion_sum[idx] = (sum > SUM_MAX) ? SUM_MAX : SUM_W'(sum);
      column++;
      if (column >= RASTER_W) begin
         column = 0;
         row++;
         if (row >= RASTER_H) row = 0;
      end
      if (r.last_in_frame) close_frame(r.frame_time);
   endtask

   initial begin
      errors      = 0;
      outstanding = 0;
      restart_map();
   end

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         restart_map();
         weight_q.delete();
      end else begin
         if (csr_write_en) period = csr_write_data;
         if (push && !full) take_pixel(req_data);
         if (pop && !empty) begin
            if (weight_q.size() == 0) begin
               $error("unexpected transaction: block_index %0d block_weight %0d",
                      rsp_data.block_index, rsp_data.block_weight);
               errors = errors + 1;
            end else begin
               e = weight_q.pop_front();
               if (rsp_data.block_index !== e.block_index) begin
                  $error("block_index expected %0d actual %0d",
                         e.block_index, rsp_data.block_index);
                  errors = errors + 1;
               end
               if (rsp_data.block_weight !== e.block_weight) begin
                  $error("block_weight expected %0d actual %0d",
                         e.block_weight, rsp_data.block_weight);
                  errors = errors + 1;
               end
            end
         end
      end
      outstanding <= weight_q.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mbwm_pkg::*;

   // worst idle time after the last result: peaks plus blend and normalize per block
   localparam int SETTLE_CYCLES = 14000;
   localparam int CYCLE_LIMIT   = 50000000;
   localparam int LINE_PIXELS   = GRID_COLS_DEF * BLOCK_WIDTH_DEF;

   logic              clock = 0;
   logic              reset = 1;
   logic              push = 0;
   logic              full;
   req_type           req_data = '0;
   logic              empty;
   logic              pop = 0;
   rsp_type           rsp_data;
   logic              csr_write_en = 0;
   logic [TIME_W-1:0] csr_write_data = '0;
   int                errors;
   int                outstanding;

   // sender pacing and receiver stall controls
   int                burst_left = 0;
   bit                no_gaps = 0;
   int                rx_mode = 0;
   bit                hold_go = 0;
   bit                hold_taken = 0;
   bit                paused = 0;
   int                cycles = 0;
   logic [TIME_W-1:0] frame_clock = 0;

   always #4 clock = ~clock;

   motion_block_weight_map DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   mbwm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .pop            (pop),
      .empty          (empty),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .errors         (errors),
      .outstanding    (outstanding)
   );

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: one long hold-off on request, otherwise a stall pattern per mode
   initial begin
      int step;
      step = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1;
            pop <= 0;
            repeat (500) @(posedge clock);
         end
         step++;
         case (rx_mode)
            0: pop <= 1;
            1: pop <= $urandom_range(0, 1);
            2: pop <= (step % 7) >= 3;
            default: pop <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // one pixel transaction, with bursts and gaps between them
   task automatic send_pixel(input logic [7:0] a, input logic [7:0] b,
                             input logic last, input logic [TIME_W-1:0] t);
      req_type r;
      if (!no_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            push <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      r.pixel_a       = a;
      r.pixel_b       = b;
      r.last_in_frame = last;
      r.frame_time    = t;
      req_data <= r;
      push     <= 1;
      do @(posedge clock); while (full);
   endtask

   // let the block finish any frame-end work before touching the register
   task automatic settle();
      push <= 0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [TIME_W-1:0] value);
      settle();
      csr_write_en   <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   // random frame time: mostly a rising clock, sometimes restart or wild values
   function automatic logic [TIME_W-1:0] pick_time();
      int k;
      k = $urandom_range(0, 99);
      frame_clock = frame_clock + $urandom_range(0, 400);
      if (k < 5) return '0;
      if (k < 10) return $urandom;
      if (k < 12) return '1;
      return frame_clock;
   endfunction

   // a frame of random length with random content, mostly well formed
   task automatic random_frame(input int len);
      logic [7:0] a, b;
      for (int i = 0; i < len; i++) begin
         a = $urandom;
         b = $urandom;
         if ($urandom_range(0, 9) == 0) begin
            a = 8'hff;
            b = 8'h00;
         end
         send_pixel(a, b, i == len - 1, pick_time());
      end
   endtask

   initial begin
      int periods[3];
      periods[0] = 1;
      periods[1] = 37;
      periods[2] = 1000;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: pixel extremes and a restart at time zero
      send_pixel(8'h00, 8'hff, 0, 32'd7);
      send_pixel(8'hff, 8'h00, 0, 32'd7);
      send_pixel(8'h00, 8'h00, 0, 32'd7);
      send_pixel(8'hff, 8'hff, 1, 32'd0);
      // frame end before the update time: peaks only
      send_pixel(8'h10, 8'h80, 0, 32'd1);
      send_pixel(8'h80, 8'h10, 0, 32'd1);
      send_pixel(8'h55, 8'haa, 1, 32'd500);
      // update at the largest time
      send_pixel(8'h01, 8'hfe, 0, 32'd0);
      send_pixel(8'hfe, 8'h01, 1, 32'hffff_ffff);
      // update with a zero global peak
      send_pixel(8'h33, 8'h33, 0, 32'd0);
      send_pixel(8'hcc, 8'hcc, 1, 32'd3000);
      // zero period: every frame end past the update time updates
      write_period(32'd0);
      send_pixel(8'h20, 8'h00, 1, 32'd5000);
      send_pixel(8'h00, 8'h40, 1, 32'd5000);
      send_pixel(8'h7f, 8'h80, 1, 32'd5000);
      frame_clock = 32'd5000;

      // random phases over several periods
      for (int p = 0; p < 3; p++) begin
         write_period(periods[p]);
         rx_mode = $urandom_range(0, 3);
         for (int n = 0; n < 180; ) begin
            int len;
            len = $urandom_range(1, 40);
            if (p == 1 && n >= 80 && !hold_go) begin
               // receiver holds off while the sender keeps pushing
               hold_go = 1;
               no_gaps = 1;
               random_frame(60);
               no_gaps = 0;
               n += 60;
            end
            if (p == 2 && n >= 80 && !paused) begin
               // sender pauses until every result has come
               paused = 1;
               push <= 0;
               @(posedge clock);
               wait (outstanding == 0);
            end
            if ($urandom_range(0, 5) == 0) rx_mode = $urandom_range(0, 3);
            no_gaps = ($urandom_range(0, 3) == 0);
            random_frame(len);
            n += len;
         end
      end
      no_gaps = 0;

      // largest period: the update time jumps past every frame time
      write_period(32'hffff_ffff);
      send_pixel(8'h90, 8'h09, 1, 32'hffff_ffff);
      send_pixel(8'h09, 8'h90, 1, 32'hffff_ffff);

      // one frame a little longer than a raster line: every block column
      // and the column wrap into the next line
      rx_mode = 0;
      no_gaps = 1;
      for (int i = 0; i < LINE_PIXELS + 32; i++)
         send_pixel(8'hff, ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00,
                    i == LINE_PIXELS + 31, 32'd12345);
      push <= 0;

      @(posedge clock);
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mbwm_pkg.sv
rtl/mbwm_front.sv
rtl/mbwm_queue.sv
rtl/mbwm_div.sv
rtl/mbwm_back.sv
rtl/motion_block_weight_map.sv
tb/mbwm_checker.sv
tb/testbench.sv
